// ----- hdl/lpfc_pkg.sv -----
// Shared types, constants and codes of the length-prefixed frame checker.
package lpfc_pkg;

    localparam int unsigned HEADER_BYTES = 9;
    localparam int unsigned MIN_FRAME    = 2 + 1 + 2 + 4 + 2;
    localparam int unsigned POS_W        = 33;
    localparam int unsigned LEN_W        = 32;
    localparam int unsigned ADDR_W       = 4;
    localparam int unsigned DATA_W       = 32;

    typedef logic [7:0]       t_byte;
    typedef logic [2:0]       t_status;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [LEN_W-1:0] t_len;
    typedef logic [1:0]       t_reg_index;

    localparam t_pos POS_MAX = {POS_W{1'b1}};

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_SHORT    = 3'd1;
    localparam t_status ST_TYPE     = 3'd2;
    localparam t_status ST_VERSION  = 3'd3;
    localparam t_status ST_MAGIC    = 3'd4;
    localparam t_status ST_LENGTH   = 3'd5;
    localparam t_status ST_CHECKSUM = 3'd6;

    localparam logic ITEM_DATA   = 1'b0;
    localparam logic ITEM_STATUS = 1'b1;

    localparam t_reg_index REG_TYPE    = 2'd0;
    localparam t_reg_index REG_VERSION = 2'd1;
    localparam t_reg_index REG_MAGIC   = 2'd2;

    typedef struct packed {
        logic [15:0] expected_type;
        logic [7:0]  expected_version;
        logic [15:0] expected_magic;
    } t_cfg;

endpackage

// ----- hdl/lpfc_if.sv -----
// Request channels of the frame checker: input bytes and result items.
interface lpfc_in_if;
    import lpfc_pkg::*;

    logic  valid;
    logic  ready;
    t_byte frame_byte;
    logic  end_of_frame;

    modport source (output valid, output frame_byte, output end_of_frame, input ready);
    modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface lpfc_out_if;
    import lpfc_pkg::*;

    logic    valid;
    logic    ready;
    logic    item_kind;
    t_byte   payload_byte;
    t_status frame_status;
    t_len    declared_length;

    modport source (output valid, output item_kind, output payload_byte,
                    output frame_status, output declared_length, input ready);
    modport sink   (input valid, input item_kind, input payload_byte,
                    input frame_status, input declared_length, output ready);
endinterface

// ----- hdl/lpfc_regs.sv -----
// APB-style configuration registers of the frame checker.
module lpfc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpfc_pkg::ADDR_W-1:0] paddr,
    input  logic [lpfc_pkg::DATA_W-1:0] pwdata,
    output logic [lpfc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lpfc_pkg::t_cfg              o_cfg
);
    import lpfc_pkg::*;

    t_cfg       r_cfg;
    t_reg_index w_index;
    logic       w_write;

    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_write) begin
            case (w_index)
                REG_TYPE:    r_cfg.expected_type    <= pwdata[15:0];
                REG_VERSION: r_cfg.expected_version <= pwdata[7:0];
                REG_MAGIC:   r_cfg.expected_magic   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_TYPE:    prdata = {16'd0, r_cfg.expected_type};
            REG_VERSION: prdata = {24'd0, r_cfg.expected_version};
            REG_MAGIC:   prdata = {16'd0, r_cfg.expected_magic};
            default:     prdata = '0;
        endcase
    end
endmodule

// ----- hdl/lpfc_core.sv -----
// Input register, per-byte frame checks and result register of the frame checker.
module lpfc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lpfc_pkg::t_cfg i_cfg,
    lpfc_in_if.sink        i_byte,
    lpfc_out_if.source     o_result
);
    import lpfc_pkg::*;

    // Input register.
    logic  r_s1_valid;
    t_byte r_s1_byte;
    logic  r_s1_last;

    // Frame state.
    t_pos    r_pos;
    t_len    r_len;
    t_status r_herr;
    logic [15:0] r_sum;
    t_byte   r_recent;

    // Result register.
    logic    r_out_valid;
    logic    r_out_kind;
    t_byte   r_out_byte;
    t_status r_out_status;
    t_len    r_out_len;

    logic        w_stall;
    logic        w_fire;
    logic        w_accept;
    logic [15:0] w_pair;
    t_pos        w_off;
    t_pos        w_end_pos;
    logic        w_is_payload;
    t_len        n_len;
    t_status     n_herr;
    t_status     w_status;
    logic        w_emit;

    assign w_stall  = r_out_valid && !o_result.ready;
    assign w_fire   = r_s1_valid && !w_stall;
    assign i_byte.ready = !r_s1_valid || !w_stall;
    assign w_accept = i_byte.valid && i_byte.ready;

    assign w_pair = {r_recent, r_s1_byte};
    assign w_off  = r_pos - t_pos'(HEADER_BYTES);
    assign w_is_payload = (r_pos >= t_pos'(HEADER_BYTES)) && (w_off < {1'b0, r_len});

    always_comb begin
        n_herr = r_herr;
        if (r_herr == ST_OK) begin
            if (r_pos == t_pos'(1) && w_pair != i_cfg.expected_type) begin
                n_herr = ST_TYPE;
            end else if (r_pos == t_pos'(2) && r_s1_byte != i_cfg.expected_version) begin
                n_herr = ST_VERSION;
            end else if (r_pos == t_pos'(4) && w_pair != i_cfg.expected_magic) begin
                n_herr = ST_MAGIC;
            end
        end
    end

    always_comb begin
        n_len = r_len;
        if (r_pos >= t_pos'(5) && r_pos <= t_pos'(8)) begin
            n_len = {r_len[LEN_W-9:0], r_s1_byte};
        end
    end

    // A frame of matching length ends at position length plus ten.
    assign w_end_pos = {1'b0, n_len} + t_pos'(MIN_FRAME - 1);

    always_comb begin
        if (r_pos < t_pos'(MIN_FRAME - 1)) begin
            w_status = ST_SHORT;
        end else if (n_herr != ST_OK) begin
            w_status = n_herr;
        end else if (r_pos != w_end_pos) begin
            w_status = ST_LENGTH;
        end else if (w_pair != r_sum) begin
            w_status = ST_CHECKSUM;
        end else begin
            w_status = ST_OK;
        end
    end

    assign w_emit = w_fire && (r_s1_last || w_is_payload);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_byte <= i_byte.frame_byte;
            r_s1_last <= i_byte.end_of_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_herr   <= ST_OK;
            r_sum    <= '0;
            r_recent <= '0;
        end else if (w_fire) begin
            if (r_s1_last) begin
                r_pos    <= '0;
                r_len    <= '0;
                r_herr   <= ST_OK;
                r_sum    <= '0;
                r_recent <= '0;
            end else begin
                r_len    <= n_len;
                r_herr   <= n_herr;
                r_recent <= r_s1_byte;
                if (w_is_payload) begin
                    r_sum <= r_sum + {8'd0, r_s1_byte};
                end
                if (r_pos != POS_MAX) begin
                    r_pos <= r_pos + t_pos'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (r_s1_last) begin
                r_out_kind   <= ITEM_STATUS;
                r_out_byte   <= '0;
                r_out_status <= w_status;
                r_out_len    <= n_len;
            end else begin
                r_out_kind   <= ITEM_DATA;
                r_out_byte   <= r_s1_byte;
                r_out_status <= ST_OK;
                r_out_len    <= '0;
            end
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.item_kind       = r_out_kind;
    assign o_result.payload_byte    = r_out_byte;
    assign o_result.frame_status    = r_out_status;
    assign o_result.declared_length = r_out_len;
endmodule

// ----- hdl/length_prefixed_frame_checker.sv -----
// Top level of the length-prefixed frame checker.
// The checker takes one frame byte per clock cycle while the result side is
// ready, and so keeps that rate under continuous traffic: each byte passes an
// input register, the header, length and checksum logic, and a result register.
// Payload bytes come out as data items as they arrive, even for a bad frame,
// and the byte marked as end of frame yields one status item with the declared
// length; downstream must drop the payload of a frame whose status is not ok.
// The expected type, version and magic are set through the APB port at byte
// addresses 0, 4 and 8 and must only be changed while no frame is in flight.
module length_prefixed_frame_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lpfc_pkg::ADDR_W-1:0] paddr,
    input  logic [lpfc_pkg::DATA_W-1:0] pwdata,
    output logic [lpfc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    lpfc_in_if.sink                     i_byte,
    lpfc_out_if.source                  o_result
);
    import lpfc_pkg::*;

    t_cfg w_cfg;

    lpfc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lpfc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_byte   (i_byte),
        .o_result (o_result)
    );
endmodule

// ----- tb/tb_top.sv -----
// Testbench of the frame checker: random frames in, predicted payload and status results out.
module tb_top;
    import lpfc_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int PHASES         = 5;
    localparam t_reg_index REG_SPARE = 2'd3;

    typedef struct packed {
        t_byte data;
        logic  eof;
    } link_byte_t;

    typedef struct {
        logic    kind;
        t_byte   pbyte;
        t_status status;
        t_len    decl;
    } checker_result_t;

    typedef enum int {
        FLAW_NONE, FLAW_TYPE, FLAW_VERSION, FLAW_MAGIC,
        FLAW_LENGTH, FLAW_CHECKSUM, FLAW_RUNT, FLAW_NOISE
    } frame_flaw_e;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic  drv_valid = 1'b0;
    t_byte drv_byte  = '0;
    logic  drv_eof   = 1'b0;
    logic  drv_ready = 1'b0;

    lpfc_in_if  byte_ch ();
    lpfc_out_if result_ch ();

    assign byte_ch.valid        = drv_valid;
    assign byte_ch.frame_byte   = drv_byte;
    assign byte_ch.end_of_frame = drv_eof;
    assign result_ch.ready      = drv_ready;

    length_prefixed_frame_checker dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    link_byte_t      bytes_to_send[$];
    checker_result_t results_due[$];
    t_cfg            cfg_now = '0;

    t_pos        f_pos    = '0;
    t_len        f_len    = '0;
    t_status     f_err    = ST_OK;
    logic [15:0] f_sum    = '0;
    logic [15:0] f_recent = '0;

    int unsigned bytes_queued   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned data_checked   = 0;
    int unsigned status_checked = 0;
    int unsigned mismatches     = 0;
    int unsigned status_seen[7] = '{default: 0};

    logic        byte_taken   = 1'b0;
    logic        gaps_on      = 1'b1;
    int unsigned in_gap_left  = 0;
    int unsigned out_gap_left = 0;
    int unsigned calm_left    = 0;
    link_byte_t      next_item;
    checker_result_t got;
    checker_result_t want;

    task automatic frame_check_step(input t_byte b, input logic last);
        t_pos            pos;
        logic [15:0]     pair;
        logic [33:0]     pay_end;
        logic [33:0]     total;
        logic            is_payload;
        t_status         st;
        checker_result_t r;
        pos        = f_pos;
        pair       = {f_recent[7:0], b};
        pay_end    = 34'(HEADER_BYTES) + 34'(f_len);
        is_payload = (pos >= t_pos'(HEADER_BYTES)) && ({1'b0, pos} < pay_end);
        if (pos == 1 && f_err == ST_OK && pair != cfg_now.expected_type) f_err = ST_TYPE;
        if (pos == 2 && f_err == ST_OK && b != cfg_now.expected_version) f_err = ST_VERSION;
        if (pos == 4 && f_err == ST_OK && pair != cfg_now.expected_magic) f_err = ST_MAGIC;
        if (pos >= 5 && pos <= 8) f_len = {f_len[23:0], b};
        if (last) begin
            total = {1'b0, pos} + 34'd1;
            if (total < 34'(MIN_FRAME)) st = ST_SHORT;
            else if (f_err != ST_OK) st = f_err;
            else if (total != 34'(f_len) + 34'(MIN_FRAME)) st = ST_LENGTH;
            else if (pair != f_sum) st = ST_CHECKSUM;
            else st = ST_OK;
            r = '{ITEM_STATUS, 8'h00, st, f_len};
            results_due.push_back(r);
            status_seen[st]++;
            f_pos    = '0;
            f_len    = '0;
            f_err    = ST_OK;
            f_sum    = '0;
            f_recent = '0;
        end else begin
            if (is_payload) begin
                f_sum = f_sum + 16'(b);
                r = '{ITEM_DATA, b, ST_OK, '0};
                results_due.push_back(r);
            end
            f_recent = {f_recent[7:0], b};
            if (f_pos != POS_MAX) f_pos = f_pos + 1'b1;
        end
    endtask

    task automatic report_field(input string field, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        byte_taken <= drv_valid && byte_ch.ready;
        if (i_rst_n && result_ch.valid && drv_ready) begin
            got = '{result_ch.item_kind, result_ch.payload_byte, result_ch.frame_status,
                    result_ch.declared_length};
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %s",
                         $time, $sformatf("kind %0d byte %0h status %0d length %0h",
                                          got.kind, got.pbyte, got.status, got.decl));
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (got.kind != want.kind)
                    report_field("item_kind", 32'(want.kind), 32'(got.kind));
                if (got.pbyte != want.pbyte)
                    report_field("payload_byte", 32'(want.pbyte), 32'(got.pbyte));
                if (got.status != want.status)
                    report_field("frame_status", 32'(want.status), 32'(got.status));
                if (got.decl != want.decl)
                    report_field("declared_length", want.decl, got.decl);
                if (want.kind == ITEM_DATA) data_checked++;
                else status_checked++;
            end
        end
        if (i_rst_n && drv_valid && byte_ch.ready) begin
            bytes_accepted++;
            frame_check_step(drv_byte, drv_eof);
        end
    end

    // The sender holds a request until it is taken, and only idles between requests.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (drv_valid && !byte_taken) begin
            end else if (in_gap_left != 0) begin
                drv_valid   <= 1'b0;
                in_gap_left <= in_gap_left - 1;
            end else if (gaps_on && calm_left == 0 && $urandom_range(0, 7) == 0) begin
                drv_valid   <= 1'b0;
                in_gap_left <= $urandom_range(0, 10);
            end else if (bytes_to_send.size() != 0) begin
                next_item = bytes_to_send.pop_front();
                drv_valid <= 1'b1;
                drv_byte  <= next_item.data;
                drv_eof   <= next_item.eof;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (calm_left != 0) calm_left <= calm_left - 1;
        else if ($urandom_range(0, 63) == 0) calm_left <= $urandom_range(20, 80);
        if (out_gap_left != 0) begin
            drv_ready    <= 1'b0;
            out_gap_left <= out_gap_left - 1;
        end else if (gaps_on && calm_left == 0 && $urandom_range(0, 7) == 0) begin
            drv_ready    <= 1'b0;
            out_gap_left <= $urandom_range(0, 10);
        end else begin
            drv_ready <= 1'b1;
        end
    end

    task automatic apb_write(input t_reg_index idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_TYPE:    cfg_now.expected_type    = value[15:0];
            REG_VERSION: cfg_now.expected_version = value[7:0];
            REG_MAGIC:   cfg_now.expected_magic   = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input t_reg_index idx, input logic [31:0] want_v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want_v) begin
            $display("%0t: register %0d read mismatch, expected %0h, actual %0h",
                     $time, idx, want_v, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        apb_check(REG_TYPE, {16'h0, cfg_now.expected_type});
        apb_check(REG_VERSION, {24'h0, cfg_now.expected_version});
        apb_check(REG_MAGIC, {16'h0, cfg_now.expected_magic});
    endtask

    task automatic set_registers(input logic [15:0] type_id, input logic [7:0] version,
                                 input logic [15:0] magic);
        apb_write(REG_TYPE, {16'($urandom), type_id});
        apb_write(REG_VERSION, {24'($urandom), version});
        apb_write(REG_MAGIC, {16'($urandom), magic});
    endtask

    task automatic push_byte(input t_byte b, input logic eof);
        bytes_to_send.push_back('{data: b, eof: eof});
        bytes_queued++;
    endtask

    task automatic queue_frame(input frame_flaw_e flaw);
        t_byte       body[$];
        logic [15:0] type_id;
        logic [15:0] magic;
        logic [15:0] csum;
        t_byte       version;
        t_len        decl;
        t_byte       pb;
        logic        bad_type;
        logic        bad_version;
        logic        bad_magic;
        int unsigned n;
        if (flaw == FLAW_RUNT || flaw == FLAW_NOISE) begin
            n = (flaw == FLAW_RUNT) ? $urandom_range(1, MIN_FRAME - 1) : $urandom_range(1, 40);
            repeat (n) body.push_back(t_byte'($urandom));
        end else begin
            bad_type    = (flaw == FLAW_TYPE);
            bad_version = (flaw == FLAW_VERSION) || (bad_type && $urandom_range(0, 1) == 1);
            bad_magic   = (flaw == FLAW_MAGIC)
                          || ((bad_type || bad_version) && $urandom_range(0, 1) == 1);
            type_id = cfg_now.expected_type;
            version = cfg_now.expected_version;
            magic   = cfg_now.expected_magic;
            if (bad_type) type_id = type_id ^ 16'(1 << $urandom_range(0, 15));
            if (bad_version) version = version ^ 8'(1 << $urandom_range(0, 7));
            if (bad_magic) magic = magic ^ 16'(1 << $urandom_range(0, 15));
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(260, 330) : $urandom_range(0, 16);
            decl = t_len'(n);
            if (flaw == FLAW_LENGTH) begin
                case ($urandom_range(0, 2))
                    0: decl = t_len'($urandom);
                    1: decl = t_len'(n + $urandom_range(1, 5));
                    default: decl = (n > 0) ? t_len'(n - $urandom_range(1, n)) : t_len'(1);
                endcase
                if (decl == t_len'(n)) decl = decl + 1'b1;
            end
            body.push_back(type_id[15:8]);
            body.push_back(type_id[7:0]);
            body.push_back(version);
            body.push_back(magic[15:8]);
            body.push_back(magic[7:0]);
            body.push_back(decl[31:24]);
            body.push_back(decl[23:16]);
            body.push_back(decl[15:8]);
            body.push_back(decl[7:0]);
            csum = '0;
            repeat (n) begin
                pb   = t_byte'($urandom);
                csum = csum + 16'(pb);
                body.push_back(pb);
            end
            if (flaw == FLAW_CHECKSUM) csum = csum ^ 16'(1 << $urandom_range(0, 15));
            body.push_back(csum[15:8]);
            body.push_back(csum[7:0]);
        end
        foreach (body[i]) push_byte(body[i], i == body.size() - 1);
    endtask

    function automatic frame_flaw_e pick_flaw();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return FLAW_NONE;
        if (r < 48) return FLAW_TYPE;
        if (r < 56) return FLAW_VERSION;
        if (r < 64) return FLAW_MAGIC;
        if (r < 76) return FLAW_LENGTH;
        if (r < 86) return FLAW_CHECKSUM;
        if (r < 94) return FLAW_RUNT;
        return FLAW_NOISE;
    endfunction

    task automatic wait_drained(input int unsigned settle);
        while (bytes_accepted != bytes_queued || results_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Run timed out with %0d results still expected.", results_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int unsigned phase_items[PHASES];
        int unsigned target;
        phase_items = '{130, 220, 250, 200, 280};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1: begin
                    set_registers(16'hFFFF, 8'hFF, 16'hFFFF);
                    apb_write(REG_SPARE, $urandom);
                end
                2: set_registers(16'($urandom), 8'($urandom), 16'($urandom));
                3: set_registers(16'h0000, 8'h00, 16'h0000);
                4: set_registers(16'($urandom), 8'($urandom), 16'($urandom));
                default: ;
            endcase
            check_registers();
            gaps_on = (ph != PHASES - 1);
            if (ph == 0) begin
                push_byte(8'h00, 1'b1);
                repeat (MIN_FRAME - 2) push_byte(8'hFF, 1'b0);
                push_byte(8'hFF, 1'b1);
                repeat (5) push_byte(8'h00, 1'b0);
                push_byte(8'hA5, 1'b0);
                push_byte(8'h5A, 1'b1);
                repeat (MIN_FRAME - 1) push_byte(8'h00, 1'b0);
                push_byte(8'h00, 1'b1);
            end
            target = bytes_queued + phase_items[ph];
            while (bytes_queued < target) queue_frame(pick_flaw());
            wait_drained(4);
        end
        wait_drained(10);
        $display("Sent %0d bytes over %0d register settings; %s",
                 bytes_accepted, PHASES,
                 $sformatf("checked %0d payload and %0d status results.",
                           data_checked, status_checked));
        $display("Status ok/short/type/version/magic/length/checksum: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_TYPE],
                 status_seen[ST_VERSION], status_seen[ST_MAGIC], status_seen[ST_LENGTH],
                 status_seen[ST_CHECKSUM]);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- length_prefixed_frame_checker.f -----
hdl/lpfc_pkg.sv
hdl/lpfc_if.sv
hdl/lpfc_regs.sv
hdl/lpfc_core.sv
hdl/length_prefixed_frame_checker.sv
tb/tb_top.sv
